FILE: src/i2c_master_byte_engine_macros.svh
// Assertion shorthands for the I2C byte engine checkers.
// Needs clk and rst_n in scope where used.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication, off during reset.
`define I2CMB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define I2CMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/i2cmb_pkg.sv
// Shared types and constants of the I2C byte engine.
// No dependencies.
package i2cmb_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam int unsigned MAX_RES     = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic       ack_to_send;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       sda_level;
        logic       scl_level;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       nack_seen;
        logic       last;
    } evt_t;

    typedef struct packed {
        evt_t [MAX_RES-1:0] res;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: src/i2cmb_front.sv
// Front end: takes requests, keeps the line and transfer state,
// and expands each request into a job of line changes. Uses i2cmb_pkg.
module i2cmb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  i2cmb_pkg::cmd_t       cmd,
    input  i2cmb_pkg::q_status_t  q_stat,
    output logic                  push,
    output i2cmb_pkg::job_t       push_job
);
    import i2cmb_pkg::*;

    logic [7:0] shift_reg, shift_next;
    logic [3:0] pos_reg, pos_next;
    logic       mode_reg, mode_next;
    logic       ack_reg, ack_next;
    logic       nack_reg, nack_next;
    logic       sda_reg, sda_next;
    logic       scl_reg, scl_next;
    logic       has_res;
    logic       take;
    logic       bit_val;
    logic [2:0] bit_idx;
    logic [7:0] cur_rb;
    logic       cur_busy;

    function automatic evt_t mk(input logic sda, input logic scl, input logic busy,
                                input logic [7:0] rb, input logic nack,
                                input logic lst);
        evt_t e;
        e.sda_level = sda;
        e.scl_level = scl;
        e.busy_res  = busy;
        e.read_byte = rb;
        e.nack_seen = nack;
        e.last      = lst;
        return e;
    endfunction

    assign cmd_stall = q_stat.full;
    assign take      = cmd_valid && !q_stat.full;
    assign push      = take && has_res;
    assign cur_rb    = mode_reg ? shift_reg : 8'd0;
    assign cur_busy  = (pos_reg != 4'd0);
    assign bit_val   = shift_reg[7];
    assign bit_idx   = 3'(4'd8 - pos_reg);

    always_comb
    begin
        shift_next = shift_reg;
        pos_next   = pos_reg;
        mode_next  = mode_reg;
        ack_next   = ack_reg;
        nack_next  = nack_reg;
        sda_next   = sda_reg;
        scl_next   = scl_reg;
        push_job   = '0;
        has_res    = 1'b0;
        case (cmd.op)
            OP_START:
            begin
                push_job.res[0] = mk(1'b1, scl_reg, cur_busy, cur_rb, nack_reg, 1'b0);
                push_job.res[1] = mk(1'b1, 1'b1, cur_busy, cur_rb, nack_reg, 1'b0);
                push_job.res[2] = mk(1'b0, 1'b1, cur_busy, cur_rb, nack_reg, 1'b0);
                push_job.res[3] = mk(1'b0, 1'b0, cur_busy, cur_rb, nack_reg, 1'b1);
                sda_next = 1'b0;
                scl_next = 1'b0;
                has_res  = 1'b1;
            end
            OP_STOP:
            begin
                push_job.res[0] = mk(1'b0, scl_reg, cur_busy, cur_rb, nack_reg, 1'b0);
                push_job.res[1] = mk(1'b0, 1'b1, cur_busy, cur_rb, nack_reg, 1'b0);
                push_job.res[2] = mk(1'b1, 1'b1, cur_busy, cur_rb, nack_reg, 1'b1);
                sda_next = 1'b1;
                scl_next = 1'b1;
                has_res  = 1'b1;
            end
            OP_WRITE:
            begin
                mode_next  = 1'b0;
                shift_next = cmd.data_byte;
                pos_next   = 4'd1;
                nack_next  = 1'b0;
            end
            OP_READ:
            begin
                mode_next  = 1'b1;
                ack_next   = cmd.ack_to_send;
                shift_next = 8'd0;
                pos_next   = 4'd1;
                sda_next   = 1'b1;
                push_job.res[0] = mk(1'b1, scl_reg, 1'b1, 8'd0, nack_reg, 1'b1);
                has_res  = 1'b1;
            end
            OP_TICK:
            begin
                if (pos_reg inside {[4'd1:4'd9]})
                begin
                    has_res  = 1'b1;
                    scl_next = 1'b0;
                    if (!mode_reg)
                    begin
                        if (pos_reg <= 4'd8)
                        begin
                            sda_next   = bit_val;
                            shift_next = {shift_reg[6:0], 1'b0};
                            pos_next   = pos_reg + 4'd1;
                            push_job.res[0] = mk(bit_val, scl_reg, 1'b1, 8'd0, nack_reg, 1'b0);
                            push_job.res[1] = mk(bit_val, 1'b1, 1'b1, 8'd0, nack_reg, 1'b0);
                            push_job.res[2] = mk(bit_val, 1'b0, 1'b1, 8'd0, nack_reg, 1'b1);
                        end
                        else
                        begin
                            sda_next  = 1'b1;
                            pos_next  = 4'd0;
                            nack_next = nack_reg | cmd.sda_in;
                            push_job.res[0] = mk(1'b1, scl_reg, 1'b1, 8'd0, nack_reg, 1'b0);
                            push_job.res[1] = mk(1'b1, 1'b1, 1'b1, 8'd0, nack_reg, 1'b0);
                            push_job.res[2] = mk(1'b1, 1'b0, 1'b0, 8'd0, nack_next, 1'b1);
                        end
                    end
                    else
                    begin
                        if (pos_reg <= 4'd8)
                        begin
                            shift_next          = shift_reg;
                            shift_next[bit_idx] = shift_reg[bit_idx] | cmd.sda_in;
                            pos_next            = pos_reg + 4'd1;
                            push_job.res[0] = mk(sda_reg, 1'b1, 1'b1, shift_reg, nack_reg, 1'b0);
                            push_job.res[1] = mk(sda_reg, 1'b0, 1'b1, shift_next, nack_reg,
                                                 1'b1);
                        end
                        else
                        begin
                            sda_next = ~ack_reg;
                            pos_next = 4'd0;
                            push_job.res[0] = mk(~ack_reg, scl_reg, 1'b1, shift_reg, nack_reg,
                                                 1'b0);
                            push_job.res[1] = mk(~ack_reg, 1'b1, 1'b1, shift_reg, nack_reg, 1'b0);
                            push_job.res[2] = mk(~ack_reg, 1'b0, 1'b0, shift_reg, nack_reg, 1'b1);
                        end
                    end
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 8'd0;
            pos_reg   <= 4'd0;
            mode_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            nack_reg  <= 1'b0;
            sda_reg   <= 1'b1;
            scl_reg   <= 1'b1;
        end
        else if (take)
        begin
            shift_reg <= shift_next;
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            ack_reg   <= ack_next;
            nack_reg  <= nack_next;
            sda_reg   <= sda_next;
            scl_reg   <= scl_next;
        end
    end

endmodule

FILE: src/i2cmb_queue.sv
// Short job queue between the front and back ends.
// Uses i2cmb_pkg.
module i2cmb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  i2cmb_pkg::job_t       push_job,
    input  logic                  pop,
    output i2cmb_pkg::job_t       pop_job,
    output i2cmb_pkg::q_status_t  stat
);
    import i2cmb_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_job    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_MAX) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_MAX) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

FILE: src/i2cmb_back.sv
// Back end: takes jobs from the queue and plays out their line changes,
// one per cycle, holding the current one while the receiver stalls. Uses i2cmb_pkg.
module i2cmb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cmb_pkg::q_status_t  q_stat,
    input  i2cmb_pkg::job_t       pop_job,
    output logic                  pop,
    output logic                  evt_valid,
    input  logic                  evt_stall,
    output i2cmb_pkg::evt_t       evt
);
    import i2cmb_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_RES);

    job_t             job_reg;
    logic             valid_reg, valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             sent;
    logic             free;

    assign evt_valid = valid_reg;
    assign evt       = job_reg.res[idx_reg];
    assign sent      = valid_reg && !evt_stall;
    assign free      = !valid_reg || (sent && evt.last);
    assign pop       = free && !q_stat.empty;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (free)
        begin
            valid_next = !q_stat.empty;
            idx_next   = '0;
        end
        else if (sent)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= pop_job;
        end
    end

endmodule

FILE: src/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine.
// Depends on i2cmb_pkg, i2cmb_front, i2cmb_queue and i2cmb_back.
//
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) takes one request per cycle while
//   cmd_stall is low: tick, write byte, read byte, start or stop. evt channel
//   (evt_valid/evt_stall/evt) returns one SDA/SCL line change per cycle while
//   evt_stall is low, with busy, read byte and NACK status; last marks the final
//   change of a request. A start gives four changes, a stop or a tick up to
//   three, a read one, a write or an idle tick none. With the back end idle, a
//   request is written into the job queue, then loaded into the back end's job
//   register, from which its first change shows on evt.
//   Sustained rate is one change per cycle at the back end while evt is not
//   stalled; a request has four changes at most.
//   Requests are taken while the two-entry job queue has room; cmd_stall rises
//   when both entries are held, either because the back end is still playing
//   out earlier changes or because the receiver stalls evt.
//   A stalled change stays on evt unchanged.
//   Reset releases both lines, clears the transfer state and empties the queue.
module i2c_master_byte_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  i2cmb_pkg::cmd_t   cmd,
    output logic              evt_valid,
    input  logic              evt_stall,
    output i2cmb_pkg::evt_t   evt
);
    import i2cmb_pkg::*;

    q_status_t q_stat;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      pop_job;

    i2cmb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    i2cmb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    i2cmb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_job   (pop_job),
        .pop       (pop),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

FILE: src/i2cmb_checker.sv
// Port-level checks of the I2C byte engine, bound to the top level.
// Uses i2cmb_pkg and i2c_master_byte_engine_macros.svh.
`include "i2c_master_byte_engine_macros.svh"

module i2cmb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input i2cmb_pkg::cmd_t   cmd,
    input logic              evt_valid,
    input logic              evt_stall,
    input i2cmb_pkg::evt_t   evt
);
    import i2cmb_pkg::*;

    // hold a stalled request
    `I2CMB_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd))

    // hold a stalled change
    `I2CMB_ASSERT_NEXT(a_evt_hold, evt_valid && evt_stall, evt_valid && $stable(evt))

    // a request's changes follow one another without a gap
    `I2CMB_ASSERT_NEXT(a_evt_cont, evt_valid && !evt_stall && !evt.last, evt_valid)

    // a full queue implies pending output
    `I2CMB_ASSERT_NOW(a_stall_pending, cmd_stall, evt_valid)

endmodule

bind i2c_master_byte_engine i2cmb_checker u_checker (.*);

FILE: dv/tb_top.sv
// Self-checking bench for i2c_master_byte_engine: directed and random requests on cmd,
// every SDA/SCL line change on evt checked against an in-bench line sequencer.
// Depends on i2cmb_pkg and the RTL top level only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmb_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO  = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI  = 3'd7;
    localparam int         SETTLE_CYCLES = 16;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic evt_stall = 1'b0;
    cmd_t cmd       = '0;
    logic cmd_stall;
    logic evt_valid;
    evt_t evt;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int requests_applied = 0;

    logic [7:0] shift_q;
    logic [3:0] bit_pos_q;
    logic       reading_q;
    logic       ack_sel_q;
    logic       nack_q;
    logic       sda_q;
    logic       scl_q;
    int         changes_now;
    evt_t       expected_changes[$];

    i2c_master_byte_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic void record_change();
        evt_t e;
        e.sda_level = sda_q;
        e.scl_level = scl_q;
        e.busy_res  = (bit_pos_q != 4'd0);
        e.read_byte = reading_q ? shift_q : 8'h00;
        e.nack_seen = nack_q;
        e.last      = 1'b0;
        expected_changes.push_back(e);
        changes_now++;
    endfunction

    function automatic void drive_sda(input logic lvl);
        sda_q = lvl;
        record_change();
    endfunction

    function automatic void drive_scl(input logic lvl);
        scl_q = lvl;
        record_change();
    endfunction

    function automatic void reset_sequencer();
        shift_q   = 8'h00;
        bit_pos_q = 4'd0;
        reading_q = 1'b0;
        ack_sel_q = 1'b0;
        nack_q    = 1'b0;
        sda_q     = 1'b1;
        scl_q     = 1'b1;
    endfunction

    // Returns 1 when the request is not ignored by the block.
    function automatic bit sequence_request(input cmd_t c);
        evt_t tail;
        bit   active_tick;
        active_tick = (bit_pos_q >= 4'd1) && (bit_pos_q <= 4'd9);
        changes_now = 0;
        case (c.op)
            OP_START:
            begin
                drive_sda(1'b1);
                drive_scl(1'b1);
                drive_sda(1'b0);
                drive_scl(1'b0);
            end
            OP_STOP:
            begin
                drive_sda(1'b0);
                drive_scl(1'b1);
                drive_sda(1'b1);
            end
            OP_WRITE:
            begin
                reading_q = 1'b0;
                shift_q   = c.data_byte;
                bit_pos_q = 4'd1;
                nack_q    = 1'b0;
            end
            OP_READ:
            begin
                reading_q = 1'b1;
                ack_sel_q = c.ack_to_send;
                shift_q   = 8'h00;
                bit_pos_q = 4'd1;
                drive_sda(1'b1);
            end
            OP_TICK:
            begin
                if (active_tick)
                begin
                    if (!reading_q && bit_pos_q <= 4'd8)
                    begin
                        drive_sda(shift_q[7]);
                        drive_scl(1'b1);
                        shift_q   = shift_q << 1;
                        bit_pos_q = bit_pos_q + 4'd1;
                    end
                    else if (!reading_q)
                    begin
                        drive_sda(1'b1);
                        drive_scl(1'b1);
                        bit_pos_q = 4'd0;
                        if (c.sda_in)
                            nack_q = 1'b1;
                    end
                    else if (bit_pos_q <= 4'd8)
                    begin
                        drive_scl(1'b1);
                        if (c.sda_in)
                            shift_q[4'd8 - bit_pos_q] = 1'b1;
                        bit_pos_q = bit_pos_q + 4'd1;
                    end
                    else
                    begin
                        drive_sda(~ack_sel_q);
                        drive_scl(1'b1);
                        bit_pos_q = 4'd0;
                    end
                    drive_scl(1'b0);
                end
            end
            default:
            begin
            end
        endcase
        if (changes_now > 0)
        begin
            tail = expected_changes.pop_back();
            tail.last = 1'b1;
            expected_changes.push_back(tail);
        end
        return (c.op <= OP_STOP) && (c.op != OP_TICK || active_tick);
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [7:0] data,
                                      input logic ack, input logic sda);
        cmd_t c;
        c.op          = op;
        c.data_byte   = data;
        c.ack_to_send = ack;
        c.sda_in      = sda;
        return c;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
        evt_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_changes
        evt_t want;
        if (rst_n && evt_valid && !evt_stall)
        begin
            if (expected_changes.size() == 0)
            begin
                $error("line change with none expected: %p", evt);
                mismatches++;
            end
            else
            begin
                want = expected_changes.pop_front();
                check_field("sda_level", int'(want.sda_level), int'(evt.sda_level));
                check_field("scl_level", int'(want.scl_level), int'(evt.scl_level));
                check_field("busy_res", int'(want.busy_res), int'(evt.busy_res));
                check_field("read_byte", int'(want.read_byte), int'(evt.read_byte));
                check_field("nack_seen", int'(want.nack_seen), int'(evt.nack_seen));
                check_field("last", int'(want.last), int'(evt.last));
            end
        end
    end

    // Call at a rising edge; returns at the edge that took the request, or after a random idle pause.
    task automatic send_request(input cmd_t c);
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        if (sequence_request(c))
            requests_applied++;
        if ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_changes();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_changes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_ticks(input int count, input logic [8:0] sda_bits);
        for (int i = 0; i < count; i++)
            send_request(make_cmd(OP_TICK, 8'($urandom), 1'($urandom), sda_bits[8 - i]));
    endtask

    task automatic test_bus_conditions();
        send_request(make_cmd(OP_TICK, 8'hFF, 1'b1, 1'b1));
        send_request(make_cmd(OP_START, 8'h00, 1'b0, 1'b0));
        send_request(make_cmd(OP_STOP, 8'hFF, 1'b1, 1'b1));
        send_request(make_cmd(OP_UNDEF_LO, 8'h00, 1'b0, 1'b0));
        send_request(make_cmd(OP_UNDEF_HI, 8'hFF, 1'b1, 1'b1));
    endtask

    task automatic test_write_byte();
        send_request(make_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b0));
        send_ticks(2, 9'h000);
        send_request(make_cmd(OP_START, 8'h00, 1'b0, 1'b0));
        send_request(make_cmd(OP_WRITE, 8'h00, 1'b1, 1'b1));
        send_ticks(9, 9'h001);
    endtask

    task automatic test_read_byte();
        send_request(make_cmd(OP_READ, 8'h00, 1'b1, 1'b0));
        send_ticks(9, {8'hA5, 1'b1});
        send_request(make_cmd(OP_WRITE, 8'h80, 1'b0, 1'b0));
        send_request(make_cmd(OP_READ, 8'hFF, 1'b0, 1'b1));
        send_ticks(3, 9'h1FF);
        send_request(make_cmd(OP_STOP, 8'h00, 1'b0, 1'b0));
        drain_changes();
    endtask

    task automatic send_bus_sequence();
        int   byte_count;
        int   tick_count;
        logic [2:0] op;
        if ($urandom_range(99) < 15)
        begin
            send_request(make_cmd(3'($urandom_range(OP_UNDEF_HI)), 8'($urandom),
                                  1'($urandom), 1'($urandom)));
        end
        else
        begin
            send_request(make_cmd(OP_START, 8'($urandom), 1'($urandom), 1'($urandom)));
            byte_count = $urandom_range(1, 3);
            for (int b = 0; b < byte_count; b++)
            begin
                op = $urandom_range(1) ? OP_WRITE : OP_READ;
                send_request(make_cmd(op, 8'($urandom), 1'($urandom), 1'($urandom)));
                tick_count = ($urandom_range(9) == 0) ? $urandom_range(0, 8) : 9;
                send_ticks(tick_count, 9'($urandom));
            end
            send_request(make_cmd(OP_STOP, 8'($urandom), 1'($urandom), 1'($urandom)));
        end
    endtask

    task automatic run_traffic(input int idle, input int stall, input int quota);
        int first;
        idle_pct  = idle;
        stall_pct = stall;
        first     = requests_applied;
        while (requests_applied - first < quota)
            send_bus_sequence();
        drain_changes();
    endtask

    task automatic test_random_traffic();
        run_traffic(0, 0, 85);
        run_traffic(70, 0, 80);
        run_traffic(0, 70, 80);
        run_traffic(18, 18, 85);
    endtask

    initial
    begin
        reset_sequencer();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct  = 30;
        stall_pct = 30;
        test_bus_conditions();
        test_write_byte();
        test_read_byte();
        test_random_traffic();
        if (expected_changes.size() != 0)
            $error("%0d line changes never arrived", expected_changes.size());
        if (mismatches == 0 && expected_changes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/i2cmb_pkg.sv
src/i2cmb_front.sv
src/i2cmb_queue.sv
src/i2cmb_back.sv
src/i2c_master_byte_engine.sv
src/i2cmb_checker.sv
dv/tb_top.sv
